/* src/bpc_pkg.sv */
package bpc_pkg;

  localparam int unsigned QuotW = 32;
  localparam int unsigned DivsrW = 17;
  localparam int unsigned NumDivCells = QuotW;

  localparam logic [2:0] RegAc1 = 3'd0;
  localparam logic [2:0] RegAc2 = 3'd1;
  localparam logic [2:0] RegAc3 = 3'd2;
  localparam logic [2:0] RegAc4 = 3'd3;
  localparam logic [2:0] RegB1 = 3'd4;
  localparam logic [2:0] RegB2 = 3'd5;

  localparam logic [17:0] PressMax = 18'h3FFFF;

  // One item in flight through the divider chain.
  typedef struct packed {
    logic              valid;
    logic              fault;
    logic              shift_after;
    logic [DivsrW-1:0] rem;
    logic [QuotW-1:0]  dq;
    logic [DivsrW-1:0] dvsr;
  } div_item_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

/* src/bpc_div_cell.sv */
module bpc_div_cell
  import bpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_item_t item_i,
  output div_item_t item_o
);

  logic [DivsrW:0] trial;
  logic            ge;
  div_item_t       item_d, item_q;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {item_i.rem, item_i.dq[QuotW-1]};
    ge = (trial >= {1'b0, item_i.dvsr});
    item_d = item_i;
    item_d.rem = ge ? DivsrW'(trial - {1'b0, item_i.dvsr}) : trial[DivsrW-1:0];
    item_d.dq = {item_i.dq[QuotW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

/* src/barometric_pressure_compensation.sv */
// Pressure compensation pipeline. Takes one item per clock cycle (busy stays
// low) and returns each result as a one-cycle result_valid_o strobe once the
// item has passed every stage; the receiver cannot stall, so sample results
// when they appear. The pipeline is the 32-cell restoring divider chain (one
// quotient bit per cell) plus five front stages for the offset and scale
// terms, one divider setup stage and three back stages for the quadratic
// correction. Calibration writes are always taken (cfg_ready_o high) and must
// only happen while no item is in flight.
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] raw_pressure_i,
  input  logic signed [20:0] temp_term_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [17:0] pressure_pa_o,
  output logic        div_fault_o
);

  // Calibration registers
  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, b1_q, b2_q;

  assign cfg_ready_o = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q <= 16'd408;
      ac2_q <= 16'hFFB8;
      ac3_q <= 16'hC7D1;
      ac4_q <= 16'd32741;
      b1_q  <= 16'd6190;
      b2_q  <= 16'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAc1: ac1_q <= cfg_data_i;
        RegAc2: ac2_q <= cfg_data_i;
        RegAc3: ac3_q <= cfg_data_i;
        RegAc4: ac4_q <= cfg_data_i;
        RegB1:  b1_q  <= cfg_data_i;
        RegB2:  b2_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the front and back stages
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, g_v_q, h_v_q;

  // Payload registers
  logic [15:0] a_up_q, b_up_q, c_up_q, d_up_q;
  logic [31:0] a_b6_q;
  logic [31:0] b_sqr_q, b_m2_q, b_m3_q;
  logic [31:0] c_pb2_q, c_pb1_q, c_m2_q, c_m3_q;
  logic [31:0] d_b3_q, d_x_q;
  logic [31:0] e_b7_q, e_b4p_q;
  logic [31:0] g_p_q, g_x1sq_q, g_m_q;
  logic        g_f_q, h_f_q;
  logic [31:0] h_p_q, h_t1_q, h_x2_q;

  logic [31:0] sq_c, x3a_c, x3b_c;

  always_comb begin
    sq_c  = asr32(b_sqr_q, 5'd12);
    x3a_c = asr32(c_pb2_q, 5'd11) + c_m2_q;
    x3b_c = asr32(c_m3_q + asr32(c_pb1_q, 5'd16) + 32'd2, 5'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      a_v_q <= start;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // B6 = B5 - 4000
    a_up_q  <= raw_pressure_i;
    a_b6_q  <= 32'(signed'(temp_term_i)) - 32'd4000;
    // products on B6
    b_up_q  <= a_up_q;
    b_sqr_q <= 32'(a_b6_q * a_b6_q);
    b_m2_q  <= 32'(sx16(ac2_q) * a_b6_q);
    b_m3_q  <= 32'(sx16(ac3_q) * a_b6_q);
    // products on the squared term
    c_up_q  <= b_up_q;
    c_pb2_q <= 32'(sx16(b2_q) * sq_c);
    c_pb1_q <= 32'(sx16(b1_q) * sq_c);
    c_m2_q  <= asr32(b_m2_q, 5'd11);
    c_m3_q  <= asr32(b_m3_q, 5'd13);
    // B3 and the scale term plus 32768
    d_up_q  <= c_up_q;
    d_b3_q  <= asr32((sx16(ac1_q) << 2) + x3a_c + 32'd2, 5'd2);
    d_x_q   <= x3b_c + 32'd32768;
    // B7 and the B4 product
    e_b7_q  <= 32'(({16'd0, d_up_q} - d_b3_q) * 32'd50000);
    e_b4p_q <= 32'({16'd0, ac4_q} * d_x_q);
  end

  // Divider setup: pick the shift rule, then hand the item to the cell chain.
  div_item_t div_in_d, div_in_q;
  div_item_t chain [NumDivCells+1];

  always_comb begin
    div_in_d.valid       = e_v_q;
    div_in_d.dvsr        = e_b4p_q[31:15];
    div_in_d.fault       = (e_b4p_q[31:15] == '0);
    div_in_d.shift_after = e_b7_q[31];
    div_in_d.rem         = '0;
    div_in_d.dq          = e_b7_q[31] ? e_b7_q : {e_b7_q[30:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_in_q <= '0;
    end else begin
      div_in_q <= div_in_d;
    end
  end

  assign chain[0] = div_in_q;

  for (genvar k = 0; k < NumDivCells; k++) begin : g_div
    bpc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (chain[k]),
      .item_o (chain[k+1])
    );
  end

  div_item_t div_out;
  logic [31:0] p_c, x1_c;

  assign div_out = chain[NumDivCells];

  always_comb begin
    p_c  = div_out.shift_after ? {div_out.dq[30:0], 1'b0} : div_out.dq;
    x1_c = asr32(p_c, 5'd8);
  end

  // Quadratic correction
  logic [31:0] corr_c, pre_c;
  logic        res_v_q, res_f_q;
  logic [17:0] res_p_q;

  always_comb begin
    corr_c = asr32(asr32(h_t1_q, 5'd16) + h_x2_q + 32'd3791, 5'd4);
    pre_c  = h_p_q + corr_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q   <= 1'b0;
      h_v_q   <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      g_v_q   <= div_out.valid;
      h_v_q   <= g_v_q;
      res_v_q <= h_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_p_q    <= p_c;
    g_f_q    <= div_out.fault;
    g_x1sq_q <= 32'(x1_c * x1_c);
    g_m_q    <= 32'(32'd7357 * p_c);
    h_p_q    <= g_p_q;
    h_f_q    <= g_f_q;
    h_t1_q   <= 32'(g_x1sq_q * 32'd3038);
    h_x2_q   <= asr32(32'd0 - g_m_q, 5'd16);
    // clamp; a zero divisor forces zero
    res_f_q  <= h_f_q;
    if (h_f_q || pre_c[31]) begin
      res_p_q <= '0;
    end else if (pre_c > {14'd0, PressMax}) begin
      res_p_q <= PressMax;
    end else begin
      res_p_q <= pre_c[17:0];
    end
  end

  assign result_valid_o = res_v_q;
  assign pressure_pa_o  = res_p_q;
  assign div_fault_o    = res_f_q;

`ifndef SYNTHESIS
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && div_fault_o) |-> (pressure_pa_o == '0))
    else $error("fault result carries nonzero pressure");

  a_back_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(div_out.valid, 3))
    else $error("result without item leaving the divider");

  a_fault_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_out.valid |-> (div_out.fault == (div_out.dvsr == '0)))
    else $error("divider fault flag out of step with divisor");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;
  import bpc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] raw_pressure_i = '0;
  logic signed [20:0] temp_term_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [17:0] pressure_pa_o;
  logic div_fault_o;

  typedef struct packed {
    logic [17:0] pa;
    logic        fault;
  } press_res_t;

  // Local copy of the calibration words, kept in step with every write.
  logic [15:0] cal_q [6];
  press_res_t pending_q[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned res_seen = 0;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 60;

  barometric_pressure_compensation dut (
    .clk_i, .rst_ni, .start, .busy, .raw_pressure_i, .temp_term_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .pressure_pa_o, .div_fault_o
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Datasheet integer sequence, 32-bit wrapping arithmetic throughout.
  function automatic press_res_t calc_pressure(input logic [15:0] up_raw,
                                               input logic [20:0] b5_raw);
    logic [31:0] b5, b6, sq, x3, b3, b4, b7, p, x1, x2, corr, pre;
    press_res_t r;
    b5 = {{11{b5_raw[20]}}, b5_raw};
    b6 = b5 - 32'd4000;
    sq = shr_s(b6 * b6, 12);
    x3 = shr_s(ext16(cal_q[RegB2]) * sq, 11) + shr_s(ext16(cal_q[RegAc2]) * b6, 11);
    b3 = shr_s(ext16(cal_q[RegAc1]) * 32'd4 + x3 + 32'd2, 2);
    x3 = shr_s(shr_s(ext16(cal_q[RegAc3]) * b6, 13)
               + shr_s(ext16(cal_q[RegB1]) * sq, 16) + 32'd2, 2);
    b4 = ({16'd0, cal_q[RegAc4]} * (x3 + 32'd32768)) >> 15;
    b7 = ({16'd0, up_raw} - b3) * 32'd50000;
    r.pa = '0;
    r.fault = 1'b0;
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = shr_s(p, 8);
    x1 = shr_s(x1 * x1 * 32'd3038, 16);
    x2 = shr_s(32'd0 - 32'd7357 * p, 16);
    corr = shr_s(x1 + x2 + 32'd3791, 4);
    pre = p + corr;
    if (pre[31]) r.pa = '0;
    else if (pre > 32'(PressMax)) r.pa = PressMax;
    else r.pa = pre[17:0];
    return r;
  endfunction

  // Check every strobed result against the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      press_res_t exp_r;
      res_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual pa=%0d fault=%0b",
                 $time, pressure_pa_o, div_fault_o);
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (pressure_pa_o !== exp_r.pa) begin
          $display("%0t pressure_pa mismatch: expected %0d actual %0d",
                   $time, exp_r.pa, pressure_pa_o);
          err_cnt++;
        end
        if (div_fault_o !== exp_r.fault) begin
          $display("%0t div_fault mismatch: expected %0b actual %0b",
                   $time, exp_r.fault, div_fault_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no item, write or result accepted.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[barometric_pressure_compensation] ERROR");
      $finish;
    end
  end

  // Drive one item and hold start until the block takes it; start stays high
  // so that the next item can follow at once, drain_pipe drops it.
  task automatic send_reading(input logic [15:0] up, input logic [20:0] b5,
                              input bit may_gap = 1'b1);
    int gap;
    gap = may_gap ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    raw_pressure_i <= up;
    temp_term_i <= b5;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(calc_pressure(up, b5));
  endtask

  // Drop start, wait for every pending result, then let the pipe drain.
  task automatic drain_pipe();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Hold the write until it is taken; load_cal drops valid after the last one.
  task automatic write_cal(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cal_q[idx] = val;
  endtask

  task automatic load_cal(input logic [15:0] ac1, ac2, ac3, ac4, b1, b2);
    drain_pipe();
    write_cal(RegAc1, ac1);
    write_cal(RegAc2, ac2);
    write_cal(RegAc3, ac3);
    write_cal(RegAc4, ac4);
    write_cal(RegB1, b1);
    write_cal(RegB2, b2);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic rand_reading(input bit may_gap);
    logic [20:0] b5;
    // Mostly realistic temperature terms, sometimes the full field.
    if ($urandom_range(0, 3) != 0) b5 = 21'($signed($urandom_range(0, 16000)) - 4000);
    else b5 = 21'($urandom);
    send_reading(16'($urandom), b5, may_gap);
  endtask

  // Field extremes at reset calibration, back to back.
  task automatic test_directed_extremes();
    send_reading(16'd0, 21'd0, 1'b0);
    send_reading(16'hFFFF, 21'd0, 1'b0);
    send_reading(16'd23843, 21'd2399, 1'b0);
    send_reading(16'd0, 21'h0F_FFFF, 1'b0);
    send_reading(16'hFFFF, 21'h10_0000, 1'b0);
    send_reading(16'h5555, 21'h0A_AAAA, 1'b0);
    send_reading(16'hAAAA, 21'h15_5555, 1'b0);
    send_reading(16'd40000, 21'd4000, 1'b0);
    send_reading(16'd30000, -21'sd4000, 1'b0);
  endtask

  // A zero sensitivity word forces a zero divisor and the fault flag.
  task automatic test_zero_divisor();
    load_cal(16'd408, 16'hFFB8, 16'hC7D1, 16'd0, 16'd6190, 16'd4);
    send_reading(16'd23843, 21'd2399);
    send_reading(16'hFFFF, 21'h10_0000);
  endtask

  // Extreme calibration words to drive clamps and wrapping intermediates.
  task automatic test_cal_extremes();
    load_cal(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_reading(16'd0, 21'd0);
    send_reading(16'hFFFF, 21'h0F_FFFF);
    send_reading(16'h1234, 21'h10_0000);
    load_cal(16'h8000, 16'h8000, 16'h8000, 16'd1, 16'h8000, 16'h8000);
    send_reading(16'd0, 21'd0);
    send_reading(16'hFFFF, 21'h0F_FFFF);
    send_reading(16'h8000, 21'h10_0000);
  endtask

  // Random readings under the reset calibration set and several random ones.
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) load_cal(16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd6190, 16'd4);
      else load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
      for (int k = 0; k < 210; k++) begin
        // Some stretches run at full rate.
        rand_reading(ph % 3 != 1);
        if (k == 100 && ph == 2) drain_pipe();
      end
    end
  endtask

  initial begin
    cal_q[RegAc1] = 16'd408;
    cal_q[RegAc2] = 16'hFFB8;
    cal_q[RegAc3] = 16'hC7D1;
    cal_q[RegAc4] = 16'd32741;
    cal_q[RegB1] = 16'd6190;
    cal_q[RegB2] = 16'd4;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_zero_divisor();
    test_cal_extremes();
    test_random_phases();
    drain_pipe();
    if (err_cnt == 0) $display("[barometric_pressure_compensation] OK");
    else $display("[barometric_pressure_compensation] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/bpc_pkg.sv
src/bpc_div_cell.sv
src/barometric_pressure_compensation.sv
verif/tb_top.sv
